// File: hdl/agsh_pkg.sv
package agsh_pkg;

    localparam int PIX_W    = 15;
    localparam int CH_W     = 8;
    localparam int COLOR_W  = 24;
    localparam int CFG_W    = 16;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 5;
    localparam int NUM_CH   = 3;
    localparam int NUM_COORD = 6;
    localparam int BLEND_QB = 10;

    localparam logic [CH_W-1:0] CH_MAX = 8'd255;
    localparam logic [CH_W-1:0] CH_MIN = 8'd0;

    typedef enum logic [2:0] {
        REG_LINE_A_X,
        REG_LINE_A_Y,
        REG_LINE_B_X,
        REG_LINE_B_Y,
        REG_FAR_X,
        REG_FAR_Y,
        REG_START_COLOR,
        REG_END_COLOR
    } reg_idx_t;

endpackage

// File: hdl/axial_gradient_shader.sv
// Linear gradient shader: each request carries one pixel coordinate and yields
// one RGB color, one request per clock when the output is not stalled. The
// pipeline runs through the bit-per-stage dividers that find the control line's
// x on the pixel's row and on the far point's row, followed by saturating
// dividers for the color blend. The gradient registers sit on the APB port; the
// user must write them only while no request is in flight, as the block itself
// does not enforce this.
module axial_gradient_shader #(
    parameter int COORD_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [agsh_pkg::ADDR_W-1:0]      paddr,
    input  logic [agsh_pkg::DATA_W-1:0]      pwdata,
    output logic [agsh_pkg::DATA_W-1:0]      prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [agsh_pkg::PIX_W-1:0]       pixel_x,
    input  logic [agsh_pkg::PIX_W-1:0]       pixel_y,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [agsh_pkg::PIX_W-1:0]       out_x,
    output logic [agsh_pkg::PIX_W-1:0]       out_y,
    output logic [agsh_pkg::CH_W-1:0]        red,
    output logic [agsh_pkg::CH_W-1:0]        green,
    output logic [agsh_pkg::CH_W-1:0]        blue
);

    localparam int PXW = agsh_pkg::PIX_W;
    localparam int CHW = agsh_pkg::CH_W;
    localparam int NCH = agsh_pkg::NUM_CH;
    localparam int EXW = (COORD_BITS > agsh_pkg::CFG_W) ? COORD_BITS : agsh_pkg::CFG_W;
    localparam int DW  = EXW + 2;
    localparam int C1  = COORD_BITS + 1;
    localparam int PW  = DW + C1;
    localparam int IW  = PW + 3;
    localparam int LOW = IW / 2;
    localparam int HIW = IW - LOW;
    localparam int NW  = IW + CHW;
    localparam int QB  = agsh_pkg::BLEND_QB;
    localparam int VW  = QB + 3;
    localparam int TW0 = 2 * PXW + 2;

    // configuration registers
    logic [agsh_pkg::CFG_W-1:0]   coord_reg [agsh_pkg::NUM_COORD];
    logic [agsh_pkg::COLOR_W-1:0] start_color_reg;
    logic [agsh_pkg::COLOR_W-1:0] end_color_reg;
    agsh_pkg::reg_idx_t           ridx;
    logic                         cfg_wr;

    assign ridx   = agsh_pkg::reg_idx_t'(paddr[agsh_pkg::ADDR_W-1:2]);
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < agsh_pkg::NUM_COORD; k++)
            begin
                coord_reg[k] <= '0;
            end
            start_color_reg <= '0;
            end_color_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (ridx) inside
                agsh_pkg::REG_LINE_A_X, agsh_pkg::REG_LINE_A_Y,
                agsh_pkg::REG_LINE_B_X, agsh_pkg::REG_LINE_B_Y,
                agsh_pkg::REG_FAR_X, agsh_pkg::REG_FAR_Y:
                    coord_reg[ridx] <= pwdata[agsh_pkg::CFG_W-1:0];
                agsh_pkg::REG_START_COLOR:
                    start_color_reg <= pwdata[agsh_pkg::COLOR_W-1:0];
                agsh_pkg::REG_END_COLOR:
                    end_color_reg <= pwdata[agsh_pkg::COLOR_W-1:0];
                default:
                    start_color_reg <= start_color_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (ridx) inside
            agsh_pkg::REG_LINE_A_X, agsh_pkg::REG_LINE_A_Y,
            agsh_pkg::REG_LINE_B_X, agsh_pkg::REG_LINE_B_Y,
            agsh_pkg::REG_FAR_X, agsh_pkg::REG_FAR_Y:
                prdata = agsh_pkg::DATA_W'(coord_reg[ridx]);
            agsh_pkg::REG_START_COLOR:
                prdata = agsh_pkg::DATA_W'(start_color_reg);
            agsh_pkg::REG_END_COLOR:
                prdata = agsh_pkg::DATA_W'(end_color_reg);
            default:
                prdata = '0;
        endcase
    end

    // coordinates as COORD_BITS-wide two's complement
    logic signed [COORD_BITS-1:0] coord [agsh_pkg::NUM_COORD];

    for (genvar g = 0; g < agsh_pkg::NUM_COORD; g++)
    begin : g_coord
        logic [EXW-1:0] ext;
        assign ext      = EXW'(coord_reg[g]);
        assign coord[g] = signed'(ext[COORD_BITS-1:0]);
    end

    logic signed [COORD_BITS-1:0] ax, ay, bx, by, fx, fy;
    logic signed [COORD_BITS-1:0] xa_o, ya_o, xb_o, yb_o;
    logic signed [C1-1:0]         dx, dy;
    logic [C1-1:0]                den_l;
    logic                         horiz;

    assign ax = coord[agsh_pkg::REG_LINE_A_X];
    assign ay = coord[agsh_pkg::REG_LINE_A_Y];
    assign bx = coord[agsh_pkg::REG_LINE_B_X];
    assign by = coord[agsh_pkg::REG_LINE_B_Y];
    assign fx = coord[agsh_pkg::REG_FAR_X];
    assign fy = coord[agsh_pkg::REG_FAR_Y];

    // order the control points so that ya <= yb
    assign xa_o  = (ay > by) ? bx : ax;
    assign ya_o  = (ay > by) ? by : ay;
    assign xb_o  = (ay > by) ? ax : bx;
    assign yb_o  = (ay > by) ? ay : by;
    assign dx    = C1'(xb_o) - C1'(xa_o);
    assign dy    = C1'(yb_o) - C1'(ya_o);
    assign horiz = (ay == by);
    assign den_l = horiz ? C1'(1) : C1'(dy);

    logic [CHW-1:0] c1   [NCH];
    logic [CHW-1:0] dmag [NCH];
    logic           dneg [NCH];

    for (genvar g = 0; g < NCH; g++)
    begin : g_color
        logic signed [CHW:0] dd;
        assign c1[g]   = start_color_reg[CHW*(NCH-1-g) +: CHW];
        assign dd      = signed'({1'b0, end_color_reg[CHW*(NCH-1-g) +: CHW]})
                       - signed'({1'b0, c1[g]});
        assign dneg[g] = dd[CHW];
        assign dmag[g] = dneg[g] ? CHW'(-dd) : dd[CHW-1:0];
    end

    // pipeline advance
    logic adv;
    logic out_valid_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // stage 1: row offsets from the lower control point
    logic                 v1_reg;
    logic [PXW-1:0]       px1_reg, py1_reg;
    logic signed [DW-1:0] tp1_reg, tf1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px1_reg <= pixel_x;
            py1_reg <= pixel_y;
            tp1_reg <= DW'(signed'({1'b0, pixel_y})) - DW'(ya_o);
            tf1_reg <= DW'(fy) - DW'(ya_o);
        end
    end

    // stage 2: times the line's x span
    logic                 v2_reg;
    logic [PXW-1:0]       px2_reg, py2_reg;
    logic signed [PW-1:0] pp2_reg, pf2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
            pp2_reg <= PW'(tp1_reg) * PW'(dx);
            pf2_reg <= PW'(tf1_reg) * PW'(dx);
        end
    end

    // stage 3: sign and magnitude
    logic           v3_reg;
    logic [PXW-1:0] px3_reg, py3_reg;
    logic           negp3_reg, negf3_reg;
    logic [PW-1:0]  magp3_reg, magf3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px3_reg   <= px2_reg;
            py3_reg   <= py2_reg;
            negp3_reg <= pp2_reg[PW-1];
            negf3_reg <= pf2_reg[PW-1];
            magp3_reg <= pp2_reg[PW-1] ? PW'(-pp2_reg) : PW'(pp2_reg);
            magf3_reg <= pf2_reg[PW-1] ? PW'(-pf2_reg) : PW'(pf2_reg);
        end
    end

    // line x dividers
    logic                 dp_valid, df_valid;
    logic [PW-1:0]        qp, qf;
    logic                 dp_ovf, df_ovf;
    logic [2*PXW:0]       dp_tag;
    logic                 df_tag;

    agsh_div #(.NW(PW), .DNW(C1), .QB(PW), .TW(2*PXW+1)) u_div_pix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v3_reg),
        .num       (magp3_reg),
        .den       (den_l),
        .tag       ({px3_reg, py3_reg, negp3_reg}),
        .out_valid (dp_valid),
        .q         (qp),
        .ovf       (dp_ovf),
        .out_tag   (dp_tag)
    );

    agsh_div #(.NW(PW), .DNW(C1), .QB(PW), .TW(1)) u_div_far (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v3_reg),
        .num       (magf3_reg),
        .den       (den_l),
        .tag       (negf3_reg),
        .out_valid (df_valid),
        .q         (qf),
        .ovf       (df_ovf),
        .out_tag   (df_tag)
    );

    // stage 4: distance from the line and span
    logic [PXW-1:0]         dpx, dpy;
    logic                   dnegp;
    logic signed [PW+1:0]   qps, qfs, lp, lf;
    logic signed [IW-1:0]   i_next, imax_next;

    assign dpx   = dp_tag[2*PXW:PXW+1];
    assign dpy   = dp_tag[PXW:1];
    assign dnegp = dp_tag[0];
    assign qps   = signed'({2'b00, qp});
    assign qfs   = signed'({2'b00, qf});
    assign lp    = (dnegp ? -qps : qps) + (PW+2)'(xa_o);
    assign lf    = (df_tag ? -qfs : qfs) + (PW+2)'(xa_o);

    always_comb
    begin
        if (horiz)
        begin
            i_next    = IW'(signed'({1'b0, dpy})) - IW'(ay);
            imax_next = IW'(fy) - IW'(ay);
        end
        else
        begin
            i_next    = IW'(signed'({1'b0, dpx})) - IW'(lp);
            imax_next = IW'(fx) - IW'(lf);
        end
    end

    logic                 v4_reg;
    logic [PXW-1:0]       px4_reg, py4_reg;
    logic signed [IW-1:0] i4_reg, imax4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg <= dp_valid && df_valid && !dp_ovf && !df_ovf;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px4_reg   <= dpx;
            py4_reg   <= dpy;
            i4_reg    <= i_next;
            imax4_reg <= imax_next;
        end
    end

    // stage 5: sign and magnitude of distance and span
    logic           v5_reg;
    logic [PXW-1:0] px5_reg, py5_reg;
    logic           ineg5_reg, mneg5_reg, mzero5_reg;
    logic [IW-1:0]  imag5_reg, mmag5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px5_reg    <= px4_reg;
            py5_reg    <= py4_reg;
            ineg5_reg  <= i4_reg[IW-1];
            imag5_reg  <= i4_reg[IW-1] ? IW'(-i4_reg) : IW'(i4_reg);
            mneg5_reg  <= imax4_reg[IW-1];
            mmag5_reg  <= imax4_reg[IW-1] ? IW'(-imax4_reg) : IW'(imax4_reg);
            mzero5_reg <= (imax4_reg == '0);
        end
    end

    // stage 6: color delta times distance, split in two partial products
    logic                  v6_reg;
    logic [PXW-1:0]        px6_reg, py6_reg;
    logic                  mzero6_reg;
    logic [IW-1:0]         mmag6_reg;
    logic [CHW+LOW-1:0]    plo6_reg [NCH];
    logic [CHW+HIW-1:0]    phi6_reg [NCH];
    logic                  neg6_reg [NCH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px6_reg    <= px5_reg;
            py6_reg    <= py5_reg;
            mzero6_reg <= mzero5_reg;
            mmag6_reg  <= mmag5_reg;
            for (int k = 0; k < NCH; k++)
            begin
                plo6_reg[k] <= (CHW+LOW)'(dmag[k]) * (CHW+LOW)'(imag5_reg[LOW-1:0]);
                phi6_reg[k] <= (CHW+HIW)'(dmag[k]) * (CHW+HIW)'(imag5_reg[IW-1:LOW]);
                neg6_reg[k] <= ineg5_reg ^ mneg5_reg ^ dneg[k];
            end
        end
    end

    // stage 7: recombine the partial products
    logic           v7_reg;
    logic [PXW-1:0] px7_reg, py7_reg;
    logic           mzero7_reg;
    logic [IW-1:0]  mmag7_reg;
    logic [NW-1:0]  num7_reg [NCH];
    logic           neg7_reg [NCH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
        end
        else if (adv)
        begin
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px7_reg    <= px6_reg;
            py7_reg    <= py6_reg;
            mzero7_reg <= mzero6_reg;
            mmag7_reg  <= mmag6_reg;
            for (int k = 0; k < NCH; k++)
            begin
                num7_reg[k] <= (NW'(phi6_reg[k]) << LOW) + NW'(plo6_reg[k]);
                neg7_reg[k] <= neg6_reg[k];
            end
        end
    end

    // blend dividers, saturating past QB quotient bits
    logic           bvalid [NCH];
    logic [QB-1:0]  bq     [NCH];
    logic           bovf   [NCH];
    logic           bneg   [NCH];
    logic [PXW-1:0] bpx, bpy;
    logic           bzero;

    for (genvar g = 0; g < NCH; g++)
    begin : g_blend
        if (g == 0)
        begin : g_lead
            logic [TW0-1:0] tag_out;

            agsh_div #(.NW(NW), .DNW(IW), .QB(QB), .TW(TW0)) u_div_blend (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (adv),
                .in_valid  (v7_reg),
                .num       (num7_reg[g]),
                .den       (mmag7_reg),
                .tag       ({px7_reg, py7_reg, mzero7_reg, neg7_reg[g]}),
                .out_valid (bvalid[g]),
                .q         (bq[g]),
                .ovf       (bovf[g]),
                .out_tag   (tag_out)
            );

            assign bpx     = tag_out[TW0-1:PXW+2];
            assign bpy     = tag_out[PXW+1:2];
            assign bzero   = tag_out[1];
            assign bneg[g] = tag_out[0];
        end
        else
        begin : g_rest
            agsh_div #(.NW(NW), .DNW(IW), .QB(QB), .TW(1)) u_div_blend (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (adv),
                .in_valid  (v7_reg),
                .num       (num7_reg[g]),
                .den       (mmag7_reg),
                .tag       (neg7_reg[g]),
                .out_valid (bvalid[g]),
                .q         (bq[g]),
                .ovf       (bovf[g]),
                .out_tag   (bneg[g])
            );
        end
    end

    // final: start color plus signed quotient, clamped; start color alone when the span is zero
    logic [CHW-1:0] chan_next [NCH];

    for (genvar g = 0; g < NCH; g++)
    begin : g_clamp
        logic signed [VW-1:0] qs, val;

        assign qs  = signed'({2'b00, bq[g]});
        assign val = signed'(VW'(c1[g])) + (bneg[g] ? -qs : qs);

        always_comb
        begin
            if (bzero)
            begin
                chan_next[g] = c1[g];
            end
            else if (bovf[g])
            begin
                chan_next[g] = bneg[g] ? agsh_pkg::CH_MIN : agsh_pkg::CH_MAX;
            end
            else if (val < 0)
            begin
                chan_next[g] = agsh_pkg::CH_MIN;
            end
            else if (val > signed'(VW'(agsh_pkg::CH_MAX)))
            begin
                chan_next[g] = agsh_pkg::CH_MAX;
            end
            else
            begin
                chan_next[g] = val[CHW-1:0];
            end
        end
    end

    logic           bvalid_all;
    logic [PXW-1:0] out_x_reg, out_y_reg;
    logic [CHW-1:0] red_reg, green_reg, blue_reg;

    assign bvalid_all = bvalid[0] && bvalid[1] && bvalid[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= bvalid_all;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && bvalid_all)
        begin
            out_x_reg <= bpx;
            out_y_reg <= bpy;
            red_reg   <= chan_next[0];
            green_reg <= chan_next[1];
            blue_reg  <= chan_next[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

// File: hdl/agsh_div.sv
module agsh_div #(
    parameter int NW  = 32,
    parameter int DNW = 16,
    parameter int QB  = 32,
    parameter int TW  = 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [NW-1:0]  num,
    input  logic [DNW-1:0] den,
    input  logic [TW-1:0]  tag,
    output logic           out_valid,
    output logic [QB-1:0]  q,
    output logic           ovf,
    output logic [TW-1:0]  out_tag
);

    localparam int CW = NW + DNW + QB;

    logic           val_reg [QB+1];
    logic [NW-1:0]  rem_reg [QB+1];
    logic [DNW-1:0] den_reg [QB+1];
    logic [QB-1:0]  q_reg   [QB+1];
    logic           ovf_reg [QB+1];
    logic [TW-1:0]  tag_reg [QB+1];

    // entry stage: flag quotients that do not fit in QB bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            val_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= (CW'(den) << QB) <= CW'(num);
            tag_reg[0] <= tag;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar s = 1; s <= QB; s++)
    begin : g_stage
        localparam int K = QB - s;
        logic [CW-1:0] sh;
        logic          take;
        logic [QB-1:0] q_next;
        logic [NW-1:0] rem_next;

        assign sh   = CW'(den_reg[s-1]) << K;
        assign take = CW'(rem_reg[s-1]) >= sh;

        always_comb
        begin
            q_next    = q_reg[s-1];
            q_next[K] = take;
            rem_next  = take ? NW'(CW'(rem_reg[s-1]) - sh) : rem_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                val_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                val_reg[s] <= val_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next;
                den_reg[s] <= den_reg[s-1];
                q_reg[s]   <= q_next;
                ovf_reg[s] <= ovf_reg[s-1];
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    assign out_valid = val_reg[QB];
    assign q         = q_reg[QB];
    assign ovf       = ovf_reg[QB];
    assign out_tag   = tag_reg[QB];

endmodule

// File: hdl/agsh_checker.sv
module agsh_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       pready,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [agsh_pkg::PIX_W-1:0] out_x,
    input logic [agsh_pkg::CH_W-1:0]  red
);

    // input side stalls exactly when a finished request is held
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow held output");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(red))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("config port not ready");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result present out of reset");

endmodule

bind axial_gradient_shader agsh_checker u_agsh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pready    (pready),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .red       (red)
);

// File: verif/axial_gradient_shader_tb.sv
`timescale 1ns / 1ps

module axial_gradient_shader_tb;

    localparam int LATENCY    = 55;
    localparam int WATCH_MAX  = 20000;
    localparam int RAND_ITEMS = 1450;

    typedef struct packed {
        logic [agsh_pkg::PIX_W-1:0] x;
        logic [agsh_pkg::PIX_W-1:0] y;
        logic [agsh_pkg::CH_W-1:0]  r;
        logic [agsh_pkg::CH_W-1:0]  g;
        logic [agsh_pkg::CH_W-1:0]  b;
    } shade_t;

    typedef struct {
        logic [agsh_pkg::PIX_W-1:0] px;
        logic [agsh_pkg::PIX_W-1:0] py;
        bit                         known;
        logic [agsh_pkg::CH_W-1:0]  r;
        logic [agsh_pkg::CH_W-1:0]  g;
        logic [agsh_pkg::CH_W-1:0]  b;
    } pixel_row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [agsh_pkg::ADDR_W-1:0] paddr;
    logic [agsh_pkg::DATA_W-1:0] pwdata;
    logic [agsh_pkg::DATA_W-1:0] prdata;
    logic pready;
    logic in_valid;
    logic in_stall;
    logic [agsh_pkg::PIX_W-1:0] pixel_x;
    logic [agsh_pkg::PIX_W-1:0] pixel_y;
    logic out_valid;
    logic out_stall;
    logic [agsh_pkg::PIX_W-1:0] out_x;
    logic [agsh_pkg::PIX_W-1:0] out_y;
    logic [agsh_pkg::CH_W-1:0] red;
    logic [agsh_pkg::CH_W-1:0] green;
    logic [agsh_pkg::CH_W-1:0] blue;

    logic [agsh_pkg::CFG_W-1:0]   coord_reg [agsh_pkg::NUM_COORD];
    logic [agsh_pkg::COLOR_W-1:0] color_start;
    logic [agsh_pkg::COLOR_W-1:0] color_end;

    shade_t shade_q [$];
    int mismatches;
    int idle_cycles;
    bit no_idle;
    bit timed_out;

    axial_gradient_shader u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .pixel_x(pixel_x), .pixel_y(pixel_y),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_x(out_x), .out_y(out_y), .red(red), .green(green), .blue(blue)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint line_x(longint t);
        longint xa, ya, xb, yb;
        xa = longint'($signed(coord_reg[agsh_pkg::REG_LINE_A_X]));
        ya = longint'($signed(coord_reg[agsh_pkg::REG_LINE_A_Y]));
        xb = longint'($signed(coord_reg[agsh_pkg::REG_LINE_B_X]));
        yb = longint'($signed(coord_reg[agsh_pkg::REG_LINE_B_Y]));
        if (ya > yb)
            return (t - yb) * (xa - xb) / (ya - yb) + xb;
        return (t - ya) * (xb - xa) / (yb - ya) + xa;
    endfunction

    function automatic logic [agsh_pkg::CH_W-1:0] mix_channel(longint i, longint imax,
                                                              longint c1, longint c2);
        longint v;
        if (imax == 0)
            return c1[agsh_pkg::CH_W-1:0];
        v = c1 + (c2 - c1) * i / imax;
        if (v < 0)
            return agsh_pkg::CH_MIN;
        if (v > 255)
            return agsh_pkg::CH_MAX;
        return v[agsh_pkg::CH_W-1:0];
    endfunction

    function automatic shade_t shade_pixel(logic [agsh_pkg::PIX_W-1:0] px,
                                           logic [agsh_pkg::PIX_W-1:0] py);
        shade_t s;
        longint ay, by, i, imax;
        ay = longint'($signed(coord_reg[agsh_pkg::REG_LINE_A_Y]));
        by = longint'($signed(coord_reg[agsh_pkg::REG_LINE_B_Y]));
        if (ay != by)
        begin
            imax = longint'($signed(coord_reg[agsh_pkg::REG_FAR_X]))
                 - line_x(longint'($signed(coord_reg[agsh_pkg::REG_FAR_Y])));
            i = longint'(px) - line_x(longint'(py));
        end
        else
        begin
            imax = longint'($signed(coord_reg[agsh_pkg::REG_FAR_Y])) - ay;
            i = longint'(py) - ay;
        end
        s.x = px;
        s.y = py;
        s.r = mix_channel(i, imax, color_start[23:16], color_end[23:16]);
        s.g = mix_channel(i, imax, color_start[15:8], color_end[15:8]);
        s.b = mix_channel(i, imax, color_start[7:0], color_end[7:0]);
        return s;
    endfunction

    task automatic write_reg(agsh_pkg::reg_idx_t idx, logic [agsh_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= agsh_pkg::ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx >= agsh_pkg::REG_START_COLOR)
        begin
            if (idx == agsh_pkg::REG_START_COLOR)
                color_start = value[agsh_pkg::COLOR_W-1:0];
            else
                color_end = value[agsh_pkg::COLOR_W-1:0];
        end
        else
            coord_reg[idx] = value[agsh_pkg::CFG_W-1:0];
        @(posedge clk);
    endtask

    task automatic load_gradient(int ax, int ay, int bx, int by, int fx, int fy,
                                 int c1, int c2);
        write_reg(agsh_pkg::REG_LINE_A_X, agsh_pkg::DATA_W'(ax));
        write_reg(agsh_pkg::REG_LINE_A_Y, agsh_pkg::DATA_W'(ay));
        write_reg(agsh_pkg::REG_LINE_B_X, agsh_pkg::DATA_W'(bx));
        write_reg(agsh_pkg::REG_LINE_B_Y, agsh_pkg::DATA_W'(by));
        write_reg(agsh_pkg::REG_FAR_X, agsh_pkg::DATA_W'(fx));
        write_reg(agsh_pkg::REG_FAR_Y, agsh_pkg::DATA_W'(fy));
        write_reg(agsh_pkg::REG_START_COLOR, agsh_pkg::DATA_W'(c1));
        write_reg(agsh_pkg::REG_END_COLOR, agsh_pkg::DATA_W'(c2));
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (shade_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10)
            @(posedge clk);
    endtask

    task automatic send_pixel(logic [agsh_pkg::PIX_W-1:0] px,
                              logic [agsh_pkg::PIX_W-1:0] py);
        while (!no_idle && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_x  <= px;
        pixel_y  <= py;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        shade_q.push_back(shade_pixel(px, py));
    endtask

    function automatic logic [agsh_pkg::PIX_W-1:0] rand_pix();
        case ($urandom_range(3))
            0: return agsh_pkg::PIX_W'($urandom_range(32767));
            1: return agsh_pkg::PIX_W'($urandom_range(600));
            2: return {agsh_pkg::PIX_W{1'b1}} - agsh_pkg::PIX_W'($urandom_range(3));
            default: return agsh_pkg::PIX_W'($urandom);
        endcase
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(4))
            0: return int'($urandom_range(65535));
            1: return int'($urandom_range(400));
            2: return $urandom_range(1) ? 32767 : 32768;
            default: return int'($urandom_range(65535)) & 16'h03ff;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= !no_idle && ($urandom_range(99) < 13);
    end

    always @(posedge clk)
    begin
        shade_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (shade_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d", out_x, out_y);
            end
            else
            begin
                want = shade_q.pop_front();
                if (want.x !== out_x || want.y !== out_y || want.r !== red
                    || want.g !== green || want.b !== blue)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d,%0d rgb %0d %0d %0d got %0d,%0d rgb %0d %0d %0d",
                                 want.x, want.y, want.r, want.g, want.b,
                                 out_x, out_y, red, green, blue);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_MAX)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    pixel_row_t pix_table [] = '{
        '{15'd0, 15'd0, 1'b1, 8'd0, 8'd0, 8'd0},
        '{15'd32767, 15'd32767, 1'b1, 8'd0, 8'd0, 8'd0},
        '{15'd32767, 15'd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{15'd0, 15'd32767, 1'b0, 8'd0, 8'd0, 8'd0},
        '{15'd21845, 15'd10922, 1'b0, 8'd0, 8'd0, 8'd0},
        '{15'd10922, 15'd21845, 1'b0, 8'd0, 8'd0, 8'd0},
        '{15'd50, 15'd100, 1'b0, 8'd0, 8'd0, 8'd0},
        '{15'd100, 15'd50, 1'b0, 8'd0, 8'd0, 8'd0}
    };

    initial
    begin
        logic [agsh_pkg::PIX_W-1:0] rx, ry;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        pixel_x = '0;
        pixel_y = '0;
        out_stall = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        for (int k = 0; k < agsh_pkg::NUM_COORD; k++)
            coord_reg[k] = '0;
        color_start = '0;
        color_end = '0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: zero span, black
        foreach (pix_table[k])
        begin
            if (pix_table[k].known)
                shade_q.push_back('{pix_table[k].px, pix_table[k].py,
                                    pix_table[k].r, pix_table[k].g, pix_table[k].b});
            else
                shade_q.push_back(shade_pixel(pix_table[k].px, pix_table[k].py));
            in_valid <= 1'b1;
            pixel_x  <= pix_table[k].px;
            pixel_y  <= pix_table[k].py;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
        end
        drain();

        // horizontal line, clamping both ways
        load_gradient(0, 10, 500, 10, 0, 110, 24'h00ff80, 24'hff0040);
        foreach (pix_table[k])
            send_pixel(pix_table[k].px, pix_table[k].py);
        drain();

        // diagonal line, extreme coordinates
        load_gradient(32'h8000, 32'h8000, 32'h7fff, 32'h7fff, 32'h7fff, 0,
                      24'hffffff, 24'h000000);
        foreach (pix_table[k])
            send_pixel(pix_table[k].px, pix_table[k].py);
        drain();

        for (int phase = 0; phase < 12; phase++)
        begin
            if (phase % 3 == 2)
                load_gradient(100, 0, 100, 400, 400, 0, int'($urandom) & 24'hffffff,
                              int'($urandom) & 24'hffffff);
            else
                load_gradient(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                              rand_coord(), rand_coord(), int'($urandom) & 24'hffffff,
                              int'($urandom) & 24'hffffff);
            no_idle = (phase == 5);
            for (int n = 0; n < RAND_ITEMS / 12; n++)
            begin
                rx = rand_pix();
                ry = rand_pix();
                if (phase % 3 == 2)
                begin
                    rx = agsh_pkg::PIX_W'($urandom_range(500));
                    ry = agsh_pkg::PIX_W'($urandom_range(400));
                end
                send_pixel(rx, ry);
                if (n == 40)
                begin
                    in_valid <= 1'b0;
                    while (shade_q.size() != 0)
                        @(posedge clk);
                end
            end
            no_idle = 1'b0;
            drain();
        end

        if (mismatches == 0 && shade_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hdl/agsh_pkg.sv
hdl/agsh_div.sv
hdl/axial_gradient_shader.sv
hdl/agsh_checker.sv
verif/axial_gradient_shader_tb.sv
